// ===== hdl/ers_pkg.sv =====
// ----------------------------------------------------------------------------
// ers_pkg: shared types and constants for the elevator request scheduler
// Floor count, status and request codes, queue entry and cell control types.
// ----------------------------------------------------------------------------
package ers_pkg;

	localparam int NUM_FLOORS = 9;
	localparam int FLOOR_W    = 4;
	localparam int LEN_W      = $clog2(NUM_FLOORS + 1);
	localparam int PIDX_W     = $clog2(NUM_FLOORS);
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 5;

	// request codes; bit 1 set means move
	localparam logic [1:0] REQ_PICKUP = 2'd0;
	localparam logic [1:0] REQ_DEST   = 2'd1;
	localparam logic [1:0] REQ_MOVE   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PENDING = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MOVED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd4;

	localparam logic HEAD_UP   = 1'b0;
	localparam logic HEAD_DOWN = 1'b1;

	typedef enum logic {
		ERS_IDLE,
		ERS_EXEC
	} ers_state_t;

	typedef struct packed {
		logic [FLOOR_W-1:0] floor;
		logic               heading;
	} ers_entry_t;

	// broadcast to every cell of the queue
	typedef struct packed {
		logic               ins;       // insert new entry this cycle
		logic               pop;       // shift queue toward head
		logic               near;      // new entry same heading and ahead of car
		ers_entry_t         new_entry;
		logic [FLOOR_W-1:0] car_floor;
	} ers_op_t;

endpackage

// ===== hdl/ers_cell.sv =====
// ----------------------------------------------------------------------------
// ers_cell: one slot of the ordered request queue
// Holds one entry, finds the insertion point with a ripple flag and shifts
// entries to or from its neighbors.
// ----------------------------------------------------------------------------
module ers_cell (
	input  logic                clk,
	input  ers_pkg::ers_op_t    op,
	input  logic                occ,        // this slot holds a queued entry
	input  logic                occ_left,   // left slot occupied (1 for head)
	input  logic                found_in,   // insert point lies left of here
	input  ers_pkg::ers_entry_t left,
	input  ers_pkg::ers_entry_t right,
	output logic                found_out,
	output ers_pkg::ers_entry_t entry
);

	import ers_pkg::*;

	ers_entry_t         entry_q;
	logic [FLOOR_W-1:0] gap_mine;
	logic [FLOOR_W-1:0] gap_new;
	logic               here;
	logic               is_tail;
	logic               take_new;
	logic               take_left;

	always_comb begin
		gap_mine = (entry_q.floor > op.car_floor) ? entry_q.floor - op.car_floor
		                                          : op.car_floor - entry_q.floor;
		gap_new  = (op.new_entry.floor > op.car_floor)
		         ? op.new_entry.floor - op.car_floor
		         : op.car_floor - op.new_entry.floor;
		here      = op.ins & op.near & occ & ~found_in & (gap_new < gap_mine);
		found_out = found_in | here;
		is_tail   = ~occ & occ_left;
		take_new  = here | (op.ins & is_tail & ~found_in);
		take_left = op.ins & found_in & (occ | is_tail);
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			entry_q <= op.new_entry;
		end else if (take_left) begin
			entry_q <= left;
		end else if (op.pop) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;

endmodule

// ===== hdl/elevator_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// elevator_request_scheduler: single-car request queue and car state
// Checks and queues pickup/destination calls, pops the queue on a move.
// ----------------------------------------------------------------------------
// The accepting edge moves the FSM to execute; done is registered from the execute
//   state. busy is high for the one execute cycle, set by the queue cell row
//   updating in a single pass; a new item is taken only when busy is low.
// Reset (arst_n low): queue empty, no floor pending, car at floor 0 heading
//   up. Queue slot contents are not cleared; only occupied slots are read.
// Results cannot be stalled: done is a one-cycle strobe.
module elevator_request_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [ers_pkg::FLOOR_W-1:0]   floor,
	input  logic                          call_direction,
	output logic                          done,
	output logic [ers_pkg::STATUS_W-1:0]  status,
	output logic [ers_pkg::FLOOR_W-1:0]   car_floor,
	output logic                          car_heading,
	output logic [ers_pkg::COUNT_W-1:0]   queued_count
);

	import ers_pkg::*;

	ers_state_t state_q, state_d;

	// captured request
	logic [1:0]         req_q;
	logic [FLOOR_W-1:0] floor_q;
	logic               dir_q;

	// car and queue bookkeeping
	logic [LEN_W-1:0]      len_q;
	logic [NUM_FLOORS-1:0] pending_q;
	logic [FLOOR_W-1:0]    car_q;
	logic                  head_q;

	// result registers
	logic                done_q;
	logic [STATUS_W-1:0] status_q;

	// cell row wiring
	ers_op_t               op;
	logic [NUM_FLOORS:0]   found;
	logic [NUM_FLOORS-1:0] occ;
	ers_entry_t            ent [NUM_FLOORS];

	// decode of the captured request
	logic                  exec;
	logic                  is_move;
	logic                  bad_floor;
	logic                  dup;
	logic                  full;
	logic                  ahead;
	logic                  new_head;
	logic [NUM_FLOORS-1:0] floor_bit;
	logic [NUM_FLOORS-1:0] dst_bit;
	logic [STATUS_W-1:0]   status_d;

	// ---------------- control FSM ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ERS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ERS_IDLE: begin
				if (start) state_d = ERS_EXEC;
			end
			ERS_EXEC: state_d = ERS_IDLE;
			default:  state_d = ERS_IDLE;
		endcase
	end

	assign busy = (state_q == ERS_EXEC);
	assign exec = busy;

	// request capture on acceptance
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q   <= req_type;
			floor_q <= floor;
			dir_q   <= call_direction;
		end
	end

	// ---------------- decode ----------------
	always_comb begin
		is_move   = (req_q & REQ_MOVE) != 2'd0;
		bad_floor = {1'b0, floor_q} >= COUNT_W'(NUM_FLOORS);
		// floor index only used when in range, so truncation is safe
		floor_bit = NUM_FLOORS'(1) << floor_q[PIDX_W-1:0];
		dst_bit   = NUM_FLOORS'(1) << ent[0].floor[PIDX_W-1:0];
		dup       = (pending_q & floor_bit) != '0;
		full      = len_q >= LEN_W'(NUM_FLOORS);
		new_head  = (req_q == REQ_PICKUP) ? dir_q : head_q;
		ahead     = (head_q == HEAD_UP) ? (floor_q >= car_q) : (floor_q <= car_q);

		if (is_move) begin
			status_d = (len_q == '0) ? ST_IDLE : ST_MOVED;
		end else if (bad_floor) begin
			status_d = ST_INVALID;
		end else if (dup) begin
			status_d = ST_PENDING;
		end else begin
			status_d = ST_QUEUED;
		end

		op.ins               = exec & (status_d == ST_QUEUED) & ~full;
		op.pop               = exec & (status_d == ST_MOVED);
		op.near              = (new_head == head_q) & ahead;
		op.new_entry.floor   = floor_q;
		op.new_entry.heading = new_head;
		op.car_floor         = car_q;
	end

	// ---------------- queue cell row ----------------
	assign found[0] = 1'b0;

	for (genvar i = 0; i < NUM_FLOORS; i++) begin : g_cell
		ers_entry_t left_e, right_e;
		logic       occ_l;

		assign occ[i] = LEN_W'(i) < len_q;

		if (i == 0) begin : g_head
			assign occ_l  = 1'b1;
			assign left_e = '0;
		end else begin : g_body
			assign occ_l  = occ[i-1];
			assign left_e = ent[i-1];
		end

		if (i == NUM_FLOORS - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_mid
			assign right_e = ent[i+1];
		end

		ers_cell u_cell (
			.clk       (clk),
			.op        (op),
			.occ       (occ[i]),
			.occ_left  (occ_l),
			.found_in  (found[i]),
			.left      (left_e),
			.right     (right_e),
			.found_out (found[i+1]),
			.entry     (ent[i])
		);
	end

	// ---------------- car state and pending map ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			pending_q <= '0;
			car_q     <= '0;
			head_q    <= HEAD_UP;
			done_q    <= 1'b0;
		end else begin
			done_q <= exec;
			if (op.ins) begin
				len_q     <= len_q + LEN_W'(1);
				pending_q <= pending_q | floor_bit;
			end else if (op.pop) begin
				len_q     <= len_q - LEN_W'(1);
				pending_q <= pending_q & ~dst_bit;
				car_q     <= ent[0].floor;
				// heading kept when the target is the car's own floor
				if (ent[0].floor > car_q) begin
					head_q <= HEAD_UP;
				end else if (ent[0].floor < car_q) begin
					head_q <= HEAD_DOWN;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= status_d;
		end
	end

	// car fields read live: they only change on the execute edge
	assign done         = done_q;
	assign status       = status_q;
	assign car_floor    = car_q;
	assign car_heading  = head_q;
	assign queued_count = COUNT_W'(len_q);

endmodule

// ===== hdl/ers_checker.sv =====
// ----------------------------------------------------------------------------
// ers_checker: port-level checks for the elevator request scheduler
// Result timing, legal status codes and queue bounds.
// ----------------------------------------------------------------------------
module ers_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [ers_pkg::STATUS_W-1:0]  status,
	input logic [ers_pkg::COUNT_W-1:0]   queued_count
);

	import ers_pkg::*;

	// every accepted item yields its result, registered after its execute state
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("no result for accepted item");

	// no result without an item in execution just before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without item");

	// status is a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_IDLE)
		else $error("undefined status code");

	// queue never exceeds one entry per floor
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		queued_count <= COUNT_W'(NUM_FLOORS))
		else $error("queue count out of range");

	// idle status only reported with an empty queue
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_IDLE |-> queued_count == '0)
		else $error("idle with queued entries");

endmodule

bind elevator_request_scheduler ers_checker u_ers_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.queued_count (queued_count)
);
